// File: sv/scrlb_pkg.sv
// Shared types and constants for the scrollback line ring buffer.
package scrlb_pkg;

    localparam int VIEW_ROWS  = 7;
    localparam int ROW_W      = 3;
    localparam int LINE_BYTES = 20;
    localparam int LINE_W     = 8 * LINE_BYTES;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    localparam logic [2:0] ACT_ADD      = 3'd0;
    localparam logic [2:0] ACT_SCROLL_UP = 3'd1;
    localparam logic [2:0] ACT_SCROLL_DN = 3'd2;
    localparam logic [2:0] ACT_UNLOCK   = 3'd3;
    localparam logic [2:0] ACT_GET_VIEW = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] text_lo;
        logic [63:0] text_mid;
        logic [31:0] text_hi;
    } req_t;

    typedef struct packed {
        logic [63:0]        row_chars_lo;
        logic [63:0]        row_chars_mid;
        logic [31:0]        row_chars_hi;
        logic [ROW_W-1:0]   row_number;
        logic               last_of_run;
        logic signed [7:0]  offset_now;
        logic               locked_now;
        logic [7:0]         lines_held;
    } rsp_t;

endpackage

// File: sv/scrlb_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module scrlb_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/scrollback_line_ring_buffer_unit.sv
// Scrollback line ring buffer: line store, view window state and result sequencing.
//
//  Channel  | Handshake           | Payload        | Transaction
//  ---------+---------------------+----------------+-----------------------------------
//  request  | req_valid/req_ready | req (req_t)    | one action with an optional line
//  response | rsp_valid/rsp_ready | rsp (rsp_t)    | one status result or one view row
//
// Add, scroll and unlock actions pass through the EXEC and STATUS states after acceptance,
// and the status result is raised from a register.
// Get view passes through the EXEC, READ and DATA states before row 0 is raised, then
// raises one row per cycle unless the response stalls, set by the single read port of the store.
// Reset clears the slot pointer, line count, view offset and lock; the store is not cleared.
// A stalled response holds the sequencer; a new request is taken only when it is idle.
module scrollback_line_ring_buffer_unit #(
    parameter int RING_DEPTH = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  scrlb_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output scrlb_pkg::rsp_t   rsp
);

    localparam int ADDR_W  = $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int SHIFT_W = ADDR_W + 1;
    localparam int W       = ADDR_W + 2;
    localparam int ROW_W   = scrlb_pkg::ROW_W;
    localparam int LINE_W  = scrlb_pkg::LINE_W;

    localparam logic signed [W-1:0] VR_S    = W'(scrlb_pkg::VIEW_ROWS);
    localparam logic signed [W-1:0] DEPTH_S = W'(RING_DEPTH);
    localparam logic [ADDR_W-1:0]   LAST_SLOT = ADDR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0]    FULL_CNT  = CNT_W'(RING_DEPTH);
    localparam logic [ROW_W-1:0]    LAST_ROW  = ROW_W'(scrlb_pkg::VIEW_ROWS - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_STATUS = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_DATA   = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [ADDR_W-1:0]         newest_reg, newest_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [SHIFT_W-1:0] shift_reg, shift_next;
    logic                      lock_reg, lock_next;
    logic [ROW_W-1:0]          emit_row_reg, emit_row_next;
    logic                      blank_reg, blank_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    scrlb_pkg::req_t           item_reg;
    scrlb_pkg::rsp_t           rsp_reg, rsp_next;

    logic                      slot_free;
    logic                      load_rsp;
    logic [LINE_W-1:0]         raw_line;
    logic [LINE_W-1:0]         clean_line;
    logic                      ended;
    logic [ADDR_W-1:0]         slot_inc;
    logic [CNT_W-1:0]          count_inc;
    logic signed [W-1:0]       shift_ext;
    logic signed [W-1:0]       count_ext;
    logic signed [W-1:0]       count_inc_ext;
    logic signed [W-1:0]       shift_up;
    logic signed [W-1:0]       shift_dn;
    logic signed [W-1:0]       oldest_win;
    logic [ROW_W-1:0]          rd_row;
    logic signed [W-1:0]       row_off;
    logic signed [W-1:0]       row_idx;
    logic                      row_ok;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [LINE_W-1:0]         rd_data;
    logic [LINE_W-1:0]         row_line;
    logic signed [31:0]        shift_wide;
    logic [31:0]               count_wide;

    scrlb_ram #(
        .WIDTH (LINE_W),
        .DEPTH (RING_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_inc),
        .wr_data (clean_line),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Bytes after the first zero byte of a line are stored as zero.
    always_comb
    begin
        raw_line = {item_reg.text_hi, item_reg.text_mid, item_reg.text_lo};
        ended    = 1'b0;
        for (int i = 0; i < scrlb_pkg::LINE_BYTES; i++)
        begin
            if (raw_line[8*i +: 8] == 8'h00)
            begin
                ended = 1'b1;
            end
            clean_line[8*i +: 8] = ended ? 8'h00 : raw_line[8*i +: 8];
        end
    end

    assign slot_inc      = (newest_reg == LAST_SLOT) ? '0 : newest_reg + 1'b1;
    assign count_inc     = (count_reg == FULL_CNT) ? count_reg : count_reg + 1'b1;
    assign shift_ext     = W'(shift_reg);
    assign count_ext     = $signed(W'(count_reg));
    assign count_inc_ext = $signed(W'(count_inc));
    assign shift_up      = W'(shift_ext + 1);
    assign shift_dn      = W'(shift_ext - 1);
    assign oldest_win    = W'(VR_S - count_ext);

    assign rd_row  = (state_reg == ST_READ) ? '0 : emit_row_reg + 1'b1;
    assign row_off = W'(shift_ext - (VR_S - 1) + $signed(W'(rd_row)));
    assign row_ok  = (count_reg != '0) && (row_off <= 0) && (row_off + count_ext >= 1);

    always_comb
    begin
        row_idx = W'($signed(W'(newest_reg)) + row_off);
        if (row_idx < 0)
        begin
            row_idx = W'(row_idx + DEPTH_S);
        end
    end

    assign rd_addr   = row_idx[ADDR_W-1:0];
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign wr_en     = (state_reg == ST_EXEC) && (item_reg.action == scrlb_pkg::ACT_ADD);
    assign row_line  = blank_reg ? {scrlb_pkg::LINE_BYTES{scrlb_pkg::SPACE_CHAR}} : rd_data;
    assign shift_wide = 32'(shift_reg);
    assign count_wide = 32'(count_reg);

    always_comb
    begin
        state_next    = state_reg;
        newest_next   = newest_reg;
        count_next    = count_reg;
        shift_next    = shift_reg;
        lock_next     = lock_reg;
        emit_row_next = emit_row_reg;
        blank_next    = blank_reg;
        rd_en         = 1'b0;
        load_rsp      = 1'b0;
        rsp_next      = rsp_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_STATUS;
                case (item_reg.action)
                    scrlb_pkg::ACT_ADD:
                    begin
                        newest_next = slot_inc;
                        count_next  = count_inc;
                        if (lock_reg && (shift_ext + count_inc_ext < VR_S))
                        begin
                            if (shift_up >= 0)
                            begin
                                shift_next = '0;
                                lock_next  = 1'b0;
                            end
                            else
                            begin
                                shift_next = SHIFT_W'(shift_up);
                            end
                        end
                    end
                    scrlb_pkg::ACT_SCROLL_UP:
                    begin
                        if (count_ext > VR_S)
                        begin
                            lock_next  = 1'b1;
                            shift_next = (shift_dn < oldest_win) ? SHIFT_W'(oldest_win)
                                                                 : SHIFT_W'(shift_dn);
                        end
                    end
                    scrlb_pkg::ACT_SCROLL_DN:
                    begin
                        if (shift_ext >= -1)
                        begin
                            shift_next = '0;
                            lock_next  = 1'b0;
                        end
                        else
                        begin
                            shift_next = SHIFT_W'(shift_up);
                        end
                    end
                    scrlb_pkg::ACT_UNLOCK:
                    begin
                        shift_next = '0;
                        lock_next  = 1'b0;
                    end
                    scrlb_pkg::ACT_GET_VIEW:
                    begin
                        state_next = ST_READ;
                    end
                    default:
                    begin
                        state_next = ST_STATUS;
                    end
                endcase
            end
            ST_STATUS:
            begin
                if (slot_free)
                begin
                    load_rsp                = 1'b1;
                    rsp_next.row_chars_lo   = '0;
                    rsp_next.row_chars_mid  = '0;
                    rsp_next.row_chars_hi   = '0;
                    rsp_next.row_number     = '0;
                    rsp_next.last_of_run    = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            ST_READ:
            begin
                rd_en         = 1'b1;
                emit_row_next = rd_row;
                blank_next    = !row_ok;
                state_next    = ST_DATA;
            end
            ST_DATA:
            begin
                if (slot_free)
                begin
                    load_rsp               = 1'b1;
                    rsp_next.row_chars_lo  = row_line[63:0];
                    rsp_next.row_chars_mid = row_line[127:64];
                    rsp_next.row_chars_hi  = row_line[159:128];
                    rsp_next.row_number    = emit_row_reg;
                    rsp_next.last_of_run   = (emit_row_reg == LAST_ROW);
                    if (emit_row_reg == LAST_ROW)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_en         = 1'b1;
                        emit_row_next = rd_row;
                        blank_next    = !row_ok;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_next.offset_now = shift_wide[7:0];
        rsp_next.locked_now = lock_reg;
        rsp_next.lines_held = count_wide[7:0];

        rsp_valid_next = load_rsp || (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            newest_reg    <= '0;
            count_reg     <= '0;
            shift_reg     <= '0;
            lock_reg      <= 1'b0;
            emit_row_reg  <= '0;
            blank_reg     <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            newest_reg    <= newest_next;
            count_reg     <= count_next;
            shift_reg     <= shift_next;
            lock_reg      <= lock_next;
            emit_row_reg  <= emit_row_next;
            blank_reg     <= blank_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_lock_means_scrolled : assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg |-> (shift_reg < 0))
        else $error("view is locked at the newest row");

    a_shift_not_positive : assert property (@(posedge clk) disable iff (!rst_n)
        shift_reg <= 0)
        else $error("view offset is newer than the newest line");

    a_count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("line count exceeds the ring depth");

    a_slot_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        newest_reg <= LAST_SLOT)
        else $error("newest slot is outside the ring");

    a_idle_only_last : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && rsp_valid_reg) |-> rsp_reg.last_of_run)
        else $error("sequencer went idle with view rows still pending");

endmodule
